### rtl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RecLen = 3;       // most bytes one item can produce
  localparam int unsigned QDepth = 4;       // record queue entries
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [1:0] RecFull = 2'd3;

  // escape tracker codes
  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendPct   = 2'd1;
  localparam logic [1:0] PendDigit = 2'd2;

  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChPct   = 8'h25;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;

  // one decoded group: up to three bytes, bytes[0] leaves first
  typedef struct packed {
    logic [RecLen-1:0][ByteW-1:0] bytes;
    logic [1:0]                   cnt;
    logic                         last;
  } upd_rec_t;

  function automatic logic is_hex(logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(logic [ByteW-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // alphanumerics and the safe punctuation stay escaped
  function automatic logic keep_encoded(logic [ByteW-1:0] v);
    return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
           (v >= 8'd65 && v <= 8'd90) || v == 8'h21 || v == 8'h24 ||
           (v >= 8'h26 && v <= 8'h2f) || v == 8'h3A || v == 8'h3B ||
           v == 8'h3D || v == 8'h3f || v == 8'h40 || v == 8'h5f;
  endfunction

  // append a byte; further bytes are dropped once three are held
  function automatic upd_rec_t rec_push(upd_rec_t r, logic [ByteW-1:0] b);
    upd_rec_t o;
    o = r;
    if (r.cnt != RecFull) begin
      o.bytes[r.cnt] = b;
      o.cnt          = r.cnt + 2'd1;
    end
    return o;
  endfunction

endpackage

### rtl/upd_front.sv
`timescale 1ns / 1ps

module upd_front import upd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output upd_rec_t         q_rec_o
);

  logic [1:0]       pend_q, pend_d;
  logic [ByteW-1:0] held_q, held_d;
  logic [ByteW-1:0] dec_v;
  logic             acc;
  upd_rec_t         rec;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign dec_v      = {hex_val(held_q), hex_val(in_byte_i)};

  always_comb begin
    rec    = '0;
    pend_d = PendNone;
    held_d = held_q;
    unique case (pend_q)
      PendPct: begin
        if (is_hex(in_byte_i)) begin
          held_d = in_byte_i;
          pend_d = PendDigit;
        end else begin
          rec = rec_push(rec, ChPct);
        end
      end
      PendDigit: begin
        if (is_hex(in_byte_i)) begin
          if (keep_encoded(dec_v)) begin
            rec = rec_push(rec, ChPct);
            rec = rec_push(rec, held_q);
            rec = rec_push(rec, in_byte_i);
          end else begin
            rec = rec_push(rec, dec_v);
          end
        end else begin
          rec = rec_push(rec, ChPct);
          rec = rec_push(rec, held_q);
        end
      end
      default: ;
    endcase

    // plain handling of the current byte unless it extended an escape
    if (!((pend_q == PendPct || pend_q == PendDigit) && is_hex(in_byte_i))) begin
      if (in_byte_i == ChPlus) begin
        rec = rec_push(rec, ChSpace);
      end else if (in_byte_i == ChPct) begin
        pend_d = PendPct;
      end else begin
        rec = rec_push(rec, in_byte_i);
      end
    end

    // end of string: flush whatever escape is open
    if (in_last_i) begin
      if (pend_d == PendPct || pend_d == PendDigit) begin
        rec = rec_push(rec, ChPct);
      end
      if (pend_d == PendDigit) begin
        rec = rec_push(rec, held_d);
      end
      pend_d = PendNone;
      held_d = '0;
    end
    rec.last = in_last_i;
  end

  assign q_push_o = acc && (rec.cnt != 2'd0);
  assign q_rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PendNone;
      held_q <= '0;
    end else if (acc) begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_last_i |=> pend_q == PendNone)
    else $error("escape state not cleared after last byte");
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_last_i |-> q_push_o)
    else $error("last byte produced no output");
`endif

endmodule

### rtl/upd_fifo.sv
`timescale 1ns / 1ps

module upd_fifo import upd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  upd_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output upd_rec_t rec_o,
  output logic     empty_o
);

  localparam logic [QPtrW-1:0] PtrLast = QPtrW'(QDepth - 1);
  localparam logic [QCntW-1:0] CntFull = QCntW'(QDepth);

  upd_rec_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("record queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("record queue underflow");
`endif

endmodule

### rtl/upd_back.sv
`timescale 1ns / 1ps

module upd_back import upd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  upd_rec_t         q_rec_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             run_end_o,
  output logic             string_end_o
);

  logic             ov_q;
  logic [1:0]       idx_q;
  logic [ByteW-1:0] byte_q;
  logic             run_q, str_q;
  logic             load, fin;

  assign load    = !q_empty_i && (!ov_q || out_ready_i);
  assign fin     = (idx_q == q_rec_i.cnt - 2'd1);
  assign q_pop_o = load && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= fin ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= q_rec_i.bytes[idx_q];
      run_q  <= fin;
      str_q  <= fin && q_rec_i.last;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = byte_q;
  assign run_end_o    = run_q;
  assign string_end_o = str_q;

`ifndef SYNTHESIS
  a_idx_in_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> idx_q < q_rec_i.cnt)
    else $error("byte index beyond record length");
`endif

endmodule

### rtl/url_percent_decoder_top.sv
`timescale 1ns / 1ps

// URL percent decoder. Bytes of an encoded string enter one item at a time on
// the in_* channel, with in_last_i on the final byte; decoded bytes leave on
// the out_* channel, run_end_o marking the last byte caused by one input item
// and string_end_o the last byte of the string. '+' becomes a space, a valid
// %XX escape becomes its byte unless that byte is alphanumeric or safe
// punctuation (then all three characters pass through), and a broken escape
// is passed on literally. The front stage classifies each item in the cycle
// it is accepted and writes a record of up to three bytes into a four-entry
// queue; the back stage drains the queue one byte per cycle while out_ready_i
// is high, into an output register. Throughput is one input item per cycle
// while items give at most one byte each and out_ready_i stays high; the
// output port moves one byte per cycle, so bursts of three-byte expansions
// fill the queue and in_ready_o drops until it drains. Items that produce
// nothing (a held '%' or digit) take no queue entry.

module url_percent_decoder_top import upd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             run_end_o,
  output logic             string_end_o
);

  // front -> queue
  logic     push, full;
  upd_rec_t push_rec;
  // queue -> back
  logic     pop, empty;
  upd_rec_t head_rec;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_rec_o    (push_rec)
  );

  upd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .empty_o (empty)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_rec_i      (head_rec),
    .q_empty_i    (empty),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

`ifndef SYNTHESIS
  a_str_implies_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_end_o)
    else $error("string end without run end");
`endif

endmodule

### sim/tb_url_percent_decoder_top.sv
`timescale 1ns / 1ps

module tb_url_percent_decoder_top;
  import upd_pkg::*;

  typedef logic [ByteW-1:0] text_t[$];

  // one predicted output byte with its two markers
  typedef struct {
    logic [ByteW-1:0] data;
    logic             run_end;
    logic             string_end;
  } dec_byte_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] in_byte_i;
  logic             in_last_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ByteW-1:0] out_byte_o;
  logic             run_end_o;
  logic             string_end_o;

  // predicted output, oldest first
  dec_byte_t        dec_expect_q[$];
  // bytes produced by the item being predicted
  logic [ByteW-1:0] step_bytes[$];
  // model copy of the escape tracker
  logic [1:0]       esc_state;
  logic [ByteW-1:0] esc_digit;

  int unsigned      tx_idle_pct;
  int unsigned      rx_stall_pct;
  logic             rx_hold;
  int unsigned      n_bad;

  url_percent_decoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .string_end_o(string_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model of the decode rules
  // ---------------------------------------------------------------------------

  // 0-9, A-F, a-f only; anything from 0x80 up is never a digit
  function automatic bit hex_char(logic [ByteW-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] nibble_of(logic [ByteW-1:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      return 4'(c - 8'h30);
    end
    if (c inside {[8'h41:8'h46]}) begin
      return 4'(c - 8'h41 + 8'd10);
    end
    return 4'(c - 8'h61 + 8'd10);
  endfunction

  // alphanumerics and safe punctuation are left in escaped form
  function automatic bit stays_escaped(logic [ByteW-1:0] v);
    return (v inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                      8'h21, 8'h24, [8'h26:8'h2F], 8'h3A, 8'h3B, 8'h3D,
                      8'h3F, 8'h40, 8'h5F});
  endfunction

  function automatic void put_byte(logic [ByteW-1:0] b);
    if (step_bytes.size() < RecLen) begin
      step_bytes.push_back(b);
    end
  endfunction

  // a byte seen outside an escape
  function automatic void take_plain(logic [ByteW-1:0] c);
    if (c == ChPlus) begin
      put_byte(ChSpace);
    end else if (c == ChPct) begin
      esc_state = PendPct;
    end else begin
      put_byte(c);
    end
  endfunction

  // works out the bytes one accepted item gives and queues them
  function automatic void decode_step(logic [ByteW-1:0] c, logic last);
    logic [ByteW-1:0] v;
    step_bytes.delete();
    case (esc_state)
      PendPct: begin
        if (hex_char(c)) begin
          esc_digit = c;
          esc_state = PendDigit;
        end else begin
          put_byte(ChPct);
          esc_state = PendNone;
          take_plain(c);
        end
      end
      PendDigit: begin
        if (hex_char(c)) begin
          v = {nibble_of(esc_digit), nibble_of(c)};
          esc_state = PendNone;
          if (stays_escaped(v)) begin
            put_byte(ChPct);
            put_byte(esc_digit);
            put_byte(c);
          end else begin
            put_byte(v);
          end
        end else begin
          put_byte(ChPct);
          put_byte(esc_digit);
          esc_state = PendNone;
          take_plain(c);
        end
      end
      default: begin
        // an unused tracker code counts as idle
        esc_state = PendNone;
        take_plain(c);
      end
    endcase
    // end of string flushes whatever escape is half done
    if (last) begin
      if (esc_state == PendPct || esc_state == PendDigit) begin
        put_byte(ChPct);
      end
      if (esc_state == PendDigit) begin
        put_byte(esc_digit);
      end
      esc_state = PendNone;
      esc_digit = '0;
    end
    foreach (step_bytes[k]) begin
      dec_expect_q.push_back('{data: step_bytes[k],
                               run_end: (k == step_bytes.size() - 1),
                               string_end: (k == step_bytes.size() - 1) && last});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when asked for
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic hold_receiver(input int unsigned cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  function automatic void flag_mismatch(string what, dec_byte_t w);
    n_bad++;
    if (n_bad <= 10) begin
      $display({"%t mismatch (%s): exp byte %h run_end %b string_end %b,",
                " got byte %h run_end %b string_end %b"},
               $realtime, what, w.data, w.run_end, w.string_end,
               out_byte_o, run_end_o, string_end_o);
    end
  endfunction

  // every byte taken from the block is matched against the oldest prediction
  always @(posedge clk_i) begin : out_chk
    dec_byte_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dec_expect_q.size() == 0) begin
        w = '{data: 'x, run_end: 'x, string_end: 'x};
        flag_mismatch("nothing expected", w);
      end else begin
        w = dec_expect_q.pop_front();
        if (out_byte_o !== w.data || run_end_o !== w.run_end ||
            string_end_o !== w.string_end) begin
          flag_mismatch("wrong field", w);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // valid is left high on return; whoever pauses next must lower it
  task automatic send_item(input logic [ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_step(b, last);
  endtask

  task automatic send_string(input text_t s);
    foreach (s[i]) begin
      send_item(s[i], i == s.size() - 1);
    end
  endtask

  // sender pauses until every predicted byte has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (dec_expect_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] rand_hex();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10) begin
      return 8'(8'h30 + v);
    end
    return $urandom_range(1) ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
  endfunction

  function automatic logic [ByteW-1:0] rand_non_hex();
    logic [ByteW-1:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (hex_char(c));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // byte extremes and the plus sign
  task automatic test_plain();
    send_string('{8'h00, 8'hFF, ChPlus, 8'h61});
  endtask

  // %20 decodes, %41 stays escaped, mixed case %fF decodes to 0xFF
  task automatic test_escapes();
    send_string('{ChPct, 8'h32, 8'h30, ChPct, 8'h34, 8'h31, ChPct, 8'h66, 8'h46});
  endtask

  // broken escapes: high byte after %, plus after a digit, % after %
  task automatic test_broken();
    send_string('{ChPct, 8'h80, ChPct, 8'h34, ChPlus, ChPct, ChPct, 8'h33, 8'h30});
  endtask

  // last byte while an escape is open: lone %, % and a digit, three-byte flush
  task automatic test_string_end();
    send_string('{ChPct});
    send_string('{ChPct, 8'h61});
    send_string('{ChPct, 8'h34, 8'h7A});
  endtask

  // receiver holds off while kept escapes pile up and stall the input
  task automatic test_backpressure();
    text_t s;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (12) begin
      s.push_back(ChPct);
      s.push_back(8'h34);
      s.push_back(8'(8'h31 + $urandom_range(8)));
    end
    fork
      hold_receiver(150);
    join_none
    send_string(s);
    wait_drained();
  endtask

  // random strings, mostly well-formed escapes with some broken ones and noise
  task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned n_items);
    int unsigned sent;
    int unsigned n_parts;
    int unsigned r;
    text_t s;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      s.delete();
      n_parts = $urandom_range(8, 1);
      repeat (n_parts) begin
        r = $urandom_range(99);
        if (r < 25) begin
          s.push_back(8'($urandom_range(255)));
        end else if (r < 35) begin
          s.push_back(ChPlus);
        end else if (r < 75) begin
          s.push_back(ChPct);
          s.push_back(rand_hex());
          s.push_back(rand_hex());
        end else if (r < 90) begin
          s.push_back(ChPct);
          if ($urandom_range(1)) begin
            s.push_back(rand_hex());
          end
          s.push_back(rand_non_hex());
        end else begin
          s.push_back(ChPct);
        end
      end
      send_string(s);
      sent += s.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_byte_i    <= '0;
    in_last_i    <= 1'b0;
    out_ready_i  <= 1'b0;
    rx_hold      <= 1'b0;
    esc_state    = PendNone;
    esc_digit    = '0;
    n_bad        = 0;
    tx_idle_pct  = 35;
    rx_stall_pct = 81;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain();
    test_escapes();
    test_broken();
    test_string_end();
    wait_drained();
    test_backpressure();
    test_random(35, 81, 80);
    test_random(81, 35, 80);
    test_random(0, 0, 80);

    wait_drained();
    // room for any stray byte still in the pipe
    repeat (10) @(posedge clk_i);
    if (n_bad == 0 && dec_expect_q.size() == 0) begin
      $display("tb_url_percent_decoder_top passed");
    end else begin
      $display("tb_url_percent_decoder_top failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3000000;
    $display("tb_url_percent_decoder_top failed");
    $finish;
  end

endmodule

### sim.f
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_fifo.sv
rtl/upd_back.sv
rtl/url_percent_decoder_top.sv
sim/tb_url_percent_decoder_top.sv
